### hdl/itba_pkg.sv
// Shared types, constants and reset values for the interval timer bar-graph alarm.
`timescale 1ns / 1ps
`default_nettype none
package itba_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int CFG_TICK_W = 16;
  localparam int CFG_CNT_W  = 8;
  localparam int CMP_W      = (TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [3:0] LONG_BARS   = 4'd10;
  localparam logic [3:0] SHORT_BARS  = 4'd5;
  localparam logic [7:0] LONG_START  = 8'h80;
  localparam logic [7:0] SHORT_START = 8'h40;
  localparam logic [7:0] FLASH_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_FLASH = 2'd1,
    PH_SLEEP = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    REG_LONG_INTERVAL  = 3'd0,
    REG_LONG_FLASH     = 3'd1,
    REG_LONG_COUNT     = 3'd2,
    REG_SHORT_INTERVAL = 3'd3,
    REG_SHORT_FLASH    = 3'd4,
    REG_SHORT_COUNT    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_TICK_W-1:0] long_interval;
    logic [CFG_TICK_W-1:0] long_flash;
    logic [CFG_CNT_W-1:0]  long_count;
    logic [CFG_TICK_W-1:0] short_interval;
    logic [CFG_TICK_W-1:0] short_flash;
    logic [CFG_CNT_W-1:0]  short_count;
  } cfg_t;

  typedef struct packed {
    phase_e                phase;
    logic                  long_mode;
    logic [TICK_WIDTH-1:0] tick_cnt;
    logic [3:0]            bars_left;
    logic [3:0]            scan_pos;
    logic [7:0]            scan_pat;
    logic [7:0]            flash_tog;
    logic [7:0]            bar_out;
    logic                  top_out;
    logic                  second_out;
    logic                  alarm_out;
  } state_t;

  typedef struct packed {
    logic timer_tick;
    logic long_pressed;
    logic short_pressed;
  } item_t;

  localparam cfg_t CFG_RESET = '{
    long_interval:  16'd1107,
    long_flash:     16'd3,
    long_count:     8'd6,
    short_interval: 16'd443,
    short_flash:    16'd1,
    short_count:    8'd10
  };

  localparam state_t STATE_RESET = '{
    phase:      PH_COUNT,
    long_mode:  1'b1,
    tick_cnt:   '0,
    bars_left:  LONG_BARS,
    scan_pos:   4'd1,
    scan_pat:   LONG_START,
    flash_tog:  8'd0,
    bar_out:    8'd0,
    top_out:    1'b0,
    second_out: 1'b0,
    alarm_out:  1'b0
  };

endpackage
`default_nettype wire

### hdl/itba_if.sv
// Request channel interfaces for the scan-pass input and the LED result.
`timescale 1ns / 1ps
`default_nettype none
interface itba_in_if;
  logic valid;
  logic ready;
  logic timer_tick;
  logic long_pressed;
  logic short_pressed;

  modport source (output valid, output timer_tick, output long_pressed,
                  output short_pressed, input ready);
  modport sink (input valid, input timer_tick, input long_pressed,
                input short_pressed, output ready);
endinterface

interface itba_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] bar_leds;
  logic       top_bar_led;
  logic       second_bar_led;
  logic       alarm_led;
  logic [1:0] phase;
  logic       in_long_mode;

  modport source (output valid, output bar_leds, output top_bar_led,
                  output second_bar_led, output alarm_led, output phase,
                  output in_long_mode, input ready);
  modport sink (input valid, input bar_leds, input top_bar_led,
                input second_bar_led, input alarm_led, input phase,
                input in_long_mode, output ready);
endinterface
`default_nettype wire

### hdl/interval_timer_bargraph_alarm_core.sv
// Accepted requests wait in the input register; each result is registered at the output.
// Throughput: one request per clock while results are taken; a result held back stalls
// the input once the input register is also full, and the state advances once per request.
// Reset: rst_ni clears the state to long mode counting with ten bars, LEDs off,
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none
module interval_timer_bargraph_alarm_core
  import itba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  itba_in_if.sink                in_if,
  itba_out_if.source             out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t   cfg;
  state_t state_q, state_d;
  item_t  item_q;
  logic   in_vld_q;
  logic   out_vld_q;
  logic   advance;
  logic   [7:0] bar_q;
  logic   top_q, second_q, alarm_q, long_q;
  phase_e phase_q;

  itba_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  itba_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .item_i  (item_q),
    .state_o (state_d)
  );

  assign advance     = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= STATE_RESET;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      item_q <= '{timer_tick:    in_if.timer_tick,
                  long_pressed:  in_if.long_pressed,
                  short_pressed: in_if.short_pressed};
    end
    if (advance) begin
      bar_q    <= state_d.bar_out;
      top_q    <= state_d.top_out;
      second_q <= state_d.second_out;
      alarm_q  <= state_d.alarm_out;
      phase_q  <= state_d.phase;
      long_q   <= state_d.long_mode;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.bar_leds       = bar_q;
  assign out_if.top_bar_led    = top_q;
  assign out_if.second_bar_led = second_q;
  assign out_if.alarm_led      = alarm_q;
  assign out_if.phase          = phase_q;
  assign out_if.in_long_mode   = long_q;

endmodule
`default_nettype wire

### hdl/itba_cfg_regs.sv
// APB-style configuration register file for the interval and flash settings.
`timescale 1ns / 1ps
`default_nettype none
module itba_cfg_regs
  import itba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_LONG_INTERVAL:  cfg_d.long_interval  = pwdata[CFG_TICK_W-1:0];
        REG_LONG_FLASH:     cfg_d.long_flash     = pwdata[CFG_TICK_W-1:0];
        REG_LONG_COUNT:     cfg_d.long_count     = pwdata[CFG_CNT_W-1:0];
        REG_SHORT_INTERVAL: cfg_d.short_interval = pwdata[CFG_TICK_W-1:0];
        REG_SHORT_FLASH:    cfg_d.short_flash    = pwdata[CFG_TICK_W-1:0];
        REG_SHORT_COUNT:    cfg_d.short_count    = pwdata[CFG_CNT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_INTERVAL:  prdata = DATA_W'(cfg_q.long_interval);
      REG_LONG_FLASH:     prdata = DATA_W'(cfg_q.long_flash);
      REG_LONG_COUNT:     prdata = DATA_W'(cfg_q.long_count);
      REG_SHORT_INTERVAL: prdata = DATA_W'(cfg_q.short_interval);
      REG_SHORT_FLASH:    prdata = DATA_W'(cfg_q.short_flash);
      REG_SHORT_COUNT:    prdata = DATA_W'(cfg_q.short_count);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### hdl/itba_step.sv
// Next-state logic for one scan pass: tick count, bar scan, buttons and alarm.
`timescale 1ns / 1ps
`default_nettype none
module itba_step
  import itba_pkg::*;
(
  input  state_t state_i,
  input  cfg_t   cfg_i,
  input  item_t  item_i,
  output state_t state_o
);

  function automatic state_t load_mode(state_t s, logic is_long);
    state_t r;
    r           = s;
    r.long_mode = is_long;
    r.phase     = PH_COUNT;
    r.bars_left = is_long ? LONG_BARS : SHORT_BARS;
    r.scan_pos  = 4'd1;
    r.scan_pat  = is_long ? LONG_START : SHORT_START;
    r.tick_cnt  = '0;
    return r;
  endfunction

  logic [3:0]       full_bars;
  logic [7:0]       start_pat;
  logic [CMP_W-1:0] interval;
  logic [CMP_W-1:0] half;
  logic [7:0]       limit;
  logic             at_pos;
  state_t           n;

  assign full_bars = state_i.long_mode ? LONG_BARS : SHORT_BARS;
  assign start_pat = state_i.long_mode ? LONG_START : SHORT_START;
  assign interval  = CMP_W'(state_i.long_mode ? cfg_i.long_interval : cfg_i.short_interval);
  assign half      = CMP_W'(state_i.long_mode ? cfg_i.long_flash : cfg_i.short_flash);
  assign limit     = state_i.long_mode ? cfg_i.long_count : cfg_i.short_count;
  assign at_pos    = (state_i.scan_pos == state_i.bars_left);

  always_comb begin
    n = state_i;
    if (state_i.phase != PH_SLEEP && item_i.timer_tick && !(&state_i.tick_cnt)) begin
      n.tick_cnt = state_i.tick_cnt + 1'b1;
    end

    if (state_i.phase == PH_COUNT) begin
      n.top_out = (state_i.bars_left == full_bars && at_pos) ? ~state_i.top_out : 1'b0;
      n.second_out = (({1'b0, state_i.bars_left} + 5'd1) >= {1'b0, full_bars} && at_pos
                      && state_i.long_mode) ? ~state_i.second_out : 1'b0;
      if (state_i.scan_pos > state_i.bars_left) begin
        n.scan_pos = 4'd1;
        n.scan_pat = start_pat;
      end else begin
        n.scan_pat = state_i.long_mode ? (state_i.scan_pat >> 1) : (state_i.scan_pat >> 2);
      end
      n.bar_out  = n.scan_pat;
      n.scan_pos = n.scan_pos + 4'd1;

      if (item_i.long_pressed) begin
        n = load_mode(n, 1'b1);
      end else if (item_i.short_pressed) begin
        n = load_mode(n, 1'b0);
      end else if (state_i.bars_left == 4'd0) begin
        n.phase     = PH_FLASH;
        n.bar_out   = 8'd0;
        n.alarm_out = 1'b1;
        n.flash_tog = 8'd0;
        n.tick_cnt  = '0;
      end else if (CMP_W'(n.tick_cnt) > interval) begin
        n.bars_left = state_i.bars_left - 4'd1;
        n.scan_pos  = 4'd1;
        n.scan_pat  = start_pat;
        n.tick_cnt  = '0;
      end
    end else if (state_i.phase == PH_FLASH) begin
      if (item_i.long_pressed) begin
        n = load_mode(n, 1'b1);
      end else if (item_i.short_pressed) begin
        n = load_mode(n, 1'b0);
      end else if (state_i.flash_tog > limit) begin
        n.flash_tog = 8'd0;
        n.alarm_out = 1'b0;
        n.tick_cnt  = '0;
        if (state_i.long_mode) begin
          n = load_mode(n, 1'b0);
        end else begin
          n.phase = PH_SLEEP;
        end
      end else if (CMP_W'(n.tick_cnt) > half) begin
        n.alarm_out = ~state_i.alarm_out;
        n.tick_cnt  = '0;
        if (state_i.flash_tog != FLASH_MAX) begin
          n.flash_tog = state_i.flash_tog + 8'd1;
        end
      end
    end else begin
      if (item_i.long_pressed) begin
        n = load_mode(n, 1'b1);
      end else if (item_i.short_pressed) begin
        n = load_mode(n, 1'b0);
      end
    end
  end

  assign state_o = n;

endmodule
`default_nettype wire

### bench/itba_led_monitor.sv
// Request and result monitor that predicts every LED result of the interval timer and checks it.
`timescale 1ns / 1ps
module itba_led_monitor
  import itba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  itba_in_if                req_ch,
  itba_out_if               led_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                mismatches,
  output int                frames_due,
  output int                frames_seen,
  output int                flash_frames,
  output int                sleep_frames
);

  localparam logic [3:0] WORK_BARS   = 4'd10;
  localparam logic [3:0] BREAK_BARS  = 4'd5;
  localparam logic [7:0] WORK_START  = 8'h80;
  localparam logic [7:0] BREAK_START = 8'h40;

  typedef struct packed {
    logic [7:0] bars;
    logic       top;
    logic       second;
    logic       alarm;
    phase_e     ph;
    logic       long_mode;
  } led_frame_t;

  logic [15:0] work_interval, work_flash, break_interval, break_flash;
  logic [7:0]  work_toggles, break_toggles;

  phase_e                ph;
  logic                  long_mode;
  logic [TICK_WIDTH-1:0] ticks;
  logic [3:0]            bars_left, scan_pos;
  logic [7:0]            scan_pat, toggles, bar_q;
  logic                  top_q, second_q, alarm_q;

  led_frame_t  led_frames_q[$];
  led_frame_t  want;
  item_t       pass_in;
  logic [31:0] reg_want;

  task automatic report(string msg);
    if (mismatches < 30) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void reload_mode(logic to_long);
    long_mode = to_long;
    ph        = PH_COUNT;
    bars_left = to_long ? WORK_BARS : BREAK_BARS;
    scan_pos  = 4'd1;
    scan_pat  = to_long ? WORK_START : BREAK_START;
    ticks     = '0;
  endfunction

  function automatic led_frame_t advance_pass(item_t it);
    logic [3:0]  full;
    logic [15:0] tick_limit;
    logic [7:0]  toggle_limit;
    logic        at_pos;
    led_frame_t  f;
    if (ph != PH_SLEEP && it.timer_tick && ticks != '1) ticks = ticks + 1'b1;
    case (ph)
      PH_COUNT: begin
        full       = long_mode ? WORK_BARS : BREAK_BARS;
        tick_limit = long_mode ? work_interval : break_interval;
        at_pos     = (scan_pos == bars_left);
        top_q      = (bars_left == full && at_pos) ? ~top_q : 1'b0;
        second_q   = (int'(bars_left) + 1 >= int'(full) && at_pos && long_mode) ?
                     ~second_q : 1'b0;
        if (scan_pos > bars_left) begin
          scan_pos = 4'd1;
          scan_pat = long_mode ? WORK_START : BREAK_START;
        end else begin
          scan_pat = scan_pat >> (long_mode ? 1 : 2);
        end
        bar_q    = scan_pat;
        scan_pos = scan_pos + 4'd1;
        if (it.long_pressed) begin
          reload_mode(1'b1);
        end else if (it.short_pressed) begin
          reload_mode(1'b0);
        end else if (bars_left == 4'd0) begin
          ph      = PH_FLASH;
          bar_q   = 8'd0;
          alarm_q = 1'b1;
          toggles = 8'd0;
          ticks   = '0;
        end else if (ticks > tick_limit) begin
          bars_left = bars_left - 4'd1;
          scan_pos  = 4'd1;
          scan_pat  = long_mode ? WORK_START : BREAK_START;
          ticks     = '0;
        end
      end
      PH_FLASH: begin
        tick_limit   = long_mode ? work_flash : break_flash;
        toggle_limit = long_mode ? work_toggles : break_toggles;
        if (it.long_pressed) begin
          reload_mode(1'b1);
        end else if (it.short_pressed) begin
          reload_mode(1'b0);
        end else if (toggles > toggle_limit) begin
          toggles = 8'd0;
          alarm_q = 1'b0;
          ticks   = '0;
          if (long_mode) reload_mode(1'b0);
          else ph = PH_SLEEP;
        end else if (ticks > tick_limit) begin
          alarm_q = ~alarm_q;
          ticks   = '0;
          if (toggles != 8'hFF) toggles = toggles + 8'd1;
        end
      end
      default: begin
        if (it.long_pressed) reload_mode(1'b1);
        else if (it.short_pressed) reload_mode(1'b0);
      end
    endcase
    f = '{bars: bar_q, top: top_q, second: second_q, alarm: alarm_q, ph: ph,
          long_mode: long_mode};
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_interval  = 16'd1107;
      work_flash     = 16'd3;
      work_toggles   = 8'd6;
      break_interval = 16'd443;
      break_flash    = 16'd1;
      break_toggles  = 8'd10;
      reload_mode(1'b1);
      toggles      = 8'd0;
      bar_q        = 8'd0;
      top_q        = 1'b0;
      second_q     = 1'b0;
      alarm_q      = 1'b0;
      led_frames_q.delete();
      mismatches   = 0;
      frames_due   = 0;
      frames_seen  = 0;
      flash_frames = 0;
      sleep_frames = 0;
    end else begin
      if (led_ch.valid && led_ch.ready) begin
        if (led_frames_q.size() == 0) begin
          report("result arrived with no request outstanding");
        end else begin
          want = led_frames_q.pop_front();
          if (led_ch.bar_leds !== want.bars)
            report($sformatf("bar_leds %h, expected %h", led_ch.bar_leds, want.bars));
          if (led_ch.top_bar_led !== want.top)
            report($sformatf("top_bar_led %b, expected %b", led_ch.top_bar_led, want.top));
          if (led_ch.second_bar_led !== want.second)
            report($sformatf("second_bar_led %b, expected %b", led_ch.second_bar_led,
                             want.second));
          if (led_ch.alarm_led !== want.alarm)
            report($sformatf("alarm_led %b, expected %b", led_ch.alarm_led, want.alarm));
          if (led_ch.phase !== want.ph)
            report($sformatf("phase %0d, expected %0d", led_ch.phase, want.ph));
          if (led_ch.in_long_mode !== want.long_mode)
            report($sformatf("in_long_mode %b, expected %b", led_ch.in_long_mode,
                             want.long_mode));
          frames_seen++;
          if (want.ph == PH_FLASH) flash_frames++;
          if (want.ph == PH_SLEEP) sleep_frames++;
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[ADDR_W-1:2]))
            REG_LONG_INTERVAL:  work_interval  = pwdata[15:0];
            REG_LONG_FLASH:     work_flash     = pwdata[15:0];
            REG_LONG_COUNT:     work_toggles   = pwdata[7:0];
            REG_SHORT_INTERVAL: break_interval = pwdata[15:0];
            REG_SHORT_FLASH:    break_flash    = pwdata[15:0];
            REG_SHORT_COUNT:    break_toggles  = pwdata[7:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_e'(paddr[ADDR_W-1:2]))
            REG_LONG_INTERVAL:  reg_want = {16'd0, work_interval};
            REG_LONG_FLASH:     reg_want = {16'd0, work_flash};
            REG_LONG_COUNT:     reg_want = {24'd0, work_toggles};
            REG_SHORT_INTERVAL: reg_want = {16'd0, break_interval};
            REG_SHORT_FLASH:    reg_want = {16'd0, break_flash};
            default:            reg_want = {24'd0, break_toggles};
          endcase
          if (prdata !== reg_want)
            report($sformatf("register read at %h gave %h, expected %h", paddr, prdata,
                             reg_want));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pass_in = '{timer_tick: req_ch.timer_tick, long_pressed: req_ch.long_pressed,
                    short_pressed: req_ch.short_pressed};
        led_frames_q.push_back(advance_pass(pass_in));
      end
      frames_due = led_frames_q.size();
    end
  end

endmodule

### bench/tb_interval_timer_bargraph_alarm_core.sv
// Top of the interval timer testbench: clock, reset, request stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb_interval_timer_bargraph_alarm_core;
  import itba_pkg::*;

  localparam int CYCLE_LIMIT    = 150000;
  localparam int SAT_PASSES     = 100;
  localparam int ALARM_PASSES   = 150;
  localparam int PHASES         = 12;
  localparam int PASSES_PER_SET = 100;
  localparam int HOLD_CYCLES    = 80;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches, frames_due, frames_seen, flash_frames, sleep_frames;
  int cycles = 0;
  int passes_sent = 0;
  int settings_used = 0;
  int holds_asked = 0;
  logic idle_on = 1'b1;
  logic [31:0] cfg_val [6];

  itba_in_if  req_ch ();
  itba_out_if led_ch ();

  interval_timer_bargraph_alarm_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (req_ch),
    .out_if  (led_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  itba_led_monitor u_led_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_ch       (req_ch),
    .led_ch       (led_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .frames_due   (frames_due),
    .frames_seen  (frames_seen),
    .flash_frames (flash_frames),
    .sleep_frames (sleep_frames)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The result side stalls at random while idle_on is set and, when asked, holds off for a long stretch.
  initial begin : led_sink
    int stall;
    int holds_done;
    holds_done   = 0;
    led_ch.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done   = holds_asked;
        led_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        led_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      led_ch.ready = 1'b1;
      do @(posedge clk_i); while (!led_ch.valid);
      @(negedge clk_i);
    end
  end

  task automatic send_pass(logic tick, logic lp, logic sp);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.timer_tick    = tick;
    req_ch.long_pressed  = lp;
    req_ch.short_pressed = sp;
    req_ch.valid         = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    passes_sent++;
  endtask

  task automatic settle();
    req_ch.valid = 1'b0;
    wait (frames_due == 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic apb_access(logic wr, reg_idx_e idx, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_regs();
    settle();
    for (int r = REG_LONG_INTERVAL; r <= REG_SHORT_COUNT; r++)
      apb_access(1'b1, reg_idx_e'(r), cfg_val[r]);
    for (int r = REG_LONG_INTERVAL; r <= REG_SHORT_COUNT; r++)
      apb_access(1'b0, reg_idx_e'(r), '0);
    settings_used++;
  endtask

  initial begin : stimulus
    logic noisy;
    req_ch.valid         = 1'b0;
    req_ch.timer_tick    = 1'b0;
    req_ch.long_pressed  = 1'b0;
    req_ch.short_pressed = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: plain scanning, each button, and both buttons at once.
    send_pass(1'b0, 1'b0, 1'b0);
    send_pass(1'b1, 1'b0, 1'b0);
    send_pass(1'b1, 1'b0, 1'b0);
    send_pass(1'b0, 1'b1, 1'b0);
    send_pass(1'b0, 1'b0, 1'b1);
    send_pass(1'b0, 1'b1, 1'b1);
    send_pass(1'b1, 1'b0, 1'b1);
    send_pass(1'b1, 1'b1, 1'b0);
    settle();
    for (int r = REG_LONG_INTERVAL; r <= REG_SHORT_COUNT; r++)
      apb_access(1'b0, reg_idx_e'(r), '0);

    // All-zero settings run the whole work, break and sleep cycle quickly.
    for (int r = REG_LONG_INTERVAL; r <= REG_SHORT_COUNT; r++) cfg_val[r] = '0;
    program_regs();
    send_pass(1'b0, 1'b1, 1'b0);
    repeat (22) send_pass(1'b1, 1'b0, 1'b0);
    send_pass(1'b0, 1'b0, 1'b1);

    // A maximal interval keeps every bar through a long run of ticks.
    cfg_val[REG_LONG_INTERVAL] = 32'hFFFF;
    program_regs();
    idle_on = 1'b0;
    send_pass(1'b0, 1'b1, 1'b0);
    repeat (SAT_PASSES) send_pass(1'b1, 1'b0, 1'b0);
    cfg_val[REG_LONG_INTERVAL] = 32'hFFFE;
    program_regs();
    send_pass(1'b1, 1'b0, 1'b0);

    // A flash limit of 255 keeps the alarm going until a button request.
    cfg_val[REG_LONG_INTERVAL] = '0;
    cfg_val[REG_LONG_FLASH]    = '0;
    cfg_val[REG_LONG_COUNT]    = 32'hFF;
    program_regs();
    send_pass(1'b0, 1'b1, 1'b0);
    repeat (ALARM_PASSES) send_pass(1'b1, 1'b0, 1'b0);
    send_pass(1'b0, 1'b0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      for (int r = REG_LONG_INTERVAL; r <= REG_SHORT_COUNT; r++) begin
        if (p == 0) begin
          cfg_val[r] = (r == REG_LONG_COUNT || r == REG_SHORT_COUNT) ? 32'hFF : 32'hFFFF;
        end else if (p == 1) begin
          cfg_val[r] = '0;
        end else if (r == REG_LONG_COUNT || r == REG_SHORT_COUNT) begin
          cfg_val[r] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                                                      $urandom_range(0, 8);
        end else if (r == REG_LONG_FLASH || r == REG_SHORT_FLASH) begin
          cfg_val[r] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
                                                      $urandom_range(0, 3);
        end else begin
          cfg_val[r] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
                                                      $urandom_range(0, 6);
        end
      end
      program_regs();
      idle_on = (p % 3 != 1);
      noisy   = (p % 4 == 3);
      if (p == 4) begin
        idle_on = 1'b0;
        holds_asked++;
      end
      if ($urandom_range(0, 1)) send_pass(1'b0, 1'b1, 1'b0);
      else send_pass(1'b0, 1'b0, 1'b1);
      for (int i = 0; i < PASSES_PER_SET; i++) begin
        if (p % 2 == 1 && i == PASSES_PER_SET / 2) settle();
        if (noisy)
          send_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          send_pass($urandom_range(0, 3) != 0, $urandom_range(0, 39) == 0,
                    $urandom_range(0, 39) == 0);
      end
    end

    req_ch.valid = 1'b0;
    wait (frames_due == 0);
    repeat (8) @(negedge clk_i);
    $display("Covered %0d scan requests under %0d register settings, %0d results checked.",
             passes_sent, settings_used, frames_seen);
    $display("Results seen while flashing: %0d, while asleep: %0d.", flash_frames,
             sleep_frames);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/itba_pkg.sv
hdl/itba_if.sv
hdl/itba_cfg_regs.sv
hdl/itba_step.sv
hdl/interval_timer_bargraph_alarm_core.sv
bench/itba_led_monitor.sv
bench/tb_interval_timer_bargraph_alarm_core.sv
